[rtl/trial_division_prime_test_macros.svh]
// Assertion macros for the trial-division prime tester.
// No dependencies; included by the top level only.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tdpt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tdpt assertion failed");

`endif

[rtl/tdpt_pkg.sv]
// Package for the trial-division prime tester: widths and sequencer states.
// No dependencies.
package tdpt_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

[rtl/trial_division_prime_test.sv]
// Trial-division prime tester: one shared restoring-division step unit under a sequencer.
// Depends on tdpt_pkg and trial_division_prime_test_macros.svh.
//
// Usage:
//   Candidate channel (i_cand_valid / o_cand_ready / i_candidate): one unsigned number
//   per transfer. Result channel (o_res_valid / i_res_ready): o_tested_value echoes the
//   candidate, o_prime_flag is 1 for a prime and 0 otherwise (0 and 1 give 0).
//   Divisors d = 2, 3, ... are tried while d*d <= candidate; d*d is kept incrementally.
//   Each remainder is built by a single compare-and-subtract unit (one quotient bit
//   per cycle) in S_DIV, after a d*d bound check in S_CHECK. Candidates below 2 go
//   straight to S_FINISH; 2 and 3 pass one bound check and are found prime. Each
//   trial divisor takes one S_CHECK and a full S_DIV pass; a zero remainder ends the
//   item as not prime, and d*d above the candidate ends it as prime. The worst case
//   at 16 bits is a prime near 65535 (254 divisors, 2 to 255).
//   Only one item is in work at a time; o_cand_ready is high only when the
//   sequencer is idle. A finished result sits in the output register, so the next
//   candidate can be taken while the receiver stalls; a second finished result then
//   waits in the sequencer until the output register frees.
//   Reset (synchronous, active low) empties the sequencer and the output register.
module trial_division_prime_test (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cand_valid,
    output logic                              o_cand_ready,
    input  logic [tdpt_pkg::VALUE_WIDTH-1:0]  i_candidate,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [tdpt_pkg::VALUE_WIDTH-1:0]  o_tested_value,
    output logic                              o_prime_flag
);
    import tdpt_pkg::*;

    `include "trial_division_prime_test_macros.svh"

    localparam logic [CNT_W-1:0] CntLast = CNT_W'(VALUE_WIDTH - 1);

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_n, n_n;
    logic [VALUE_WIDTH-1:0] r_d, n_d;
    logic [VALUE_WIDTH:0]   r_sq, n_sq;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_verdict, n_verdict;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic                   r_out_prime, n_out_prime;

    logic                   cand_xfer;
    logic                   res_xfer;
    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   rem_diff;
    logic [VALUE_WIDTH-1:0] rem_next;

    assign cand_xfer = i_cand_valid && o_cand_ready;
    assign res_xfer  = r_out_valid && i_res_ready;

    // shared step unit: shift in next dividend bit, subtract divisor if it fits
    assign rem_sh   = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, r_d};
    assign rem_next = rem_diff[VALUE_WIDTH] ? rem_sh[VALUE_WIDTH-1:0]
                                            : rem_diff[VALUE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n         <= n_n;
        r_d         <= n_d;
        r_sq        <= n_sq;
        r_rem       <= n_rem;
        r_shift     <= n_shift;
        r_cnt       <= n_cnt;
        r_verdict   <= n_verdict;
        r_out_value <= n_out_value;
        r_out_prime <= n_out_prime;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_shift     = r_shift;
        n_cnt       = r_cnt;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid && !res_xfer;
        n_out_value = r_out_value;
        n_out_prime = r_out_prime;
        o_cand_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_cand_ready = 1'b1;
                if (i_cand_valid) begin
                    n_n  = i_candidate;
                    n_d  = VALUE_WIDTH'(2);
                    n_sq = (VALUE_WIDTH + 1)'(4);
                    if (i_candidate < VALUE_WIDTH'(2)) begin
                        n_verdict = 1'b0;
                        n_state   = S_FINISH;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sq > {1'b0, r_n}) begin
                    n_verdict = 1'b1;
                    n_state   = S_FINISH;
                end else begin
                    n_rem   = '0;
                    n_shift = r_n;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem   = rem_next;
                n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CntLast) begin
                    if (rem_next == '0) begin
                        n_verdict = 1'b0;
                        n_state   = S_FINISH;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_sq    = r_sq + {r_d, 1'b1};
                        n_d     = r_d + VALUE_WIDTH'(1);
                        n_state = S_CHECK;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_n;
                    n_out_prime = r_verdict;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_valid    = r_out_valid;
    assign o_tested_value = r_out_value;
    assign o_prime_flag   = r_out_prime;

    `TDPT_ASSERT_NOW(a_prime_ge_two, i_clk, i_rst_n, o_res_valid && o_prime_flag, o_tested_value >= VALUE_WIDTH'(2))
    `TDPT_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_d)
    `TDPT_ASSERT_NOW(a_div_ge_two, i_clk, i_rst_n, r_state == S_CHECK || r_state == S_DIV, r_d >= VALUE_WIDTH'(2))
    `TDPT_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, cand_xfer, r_state != S_IDLE)

endmodule
